>>> sv/iffl_pkg.sv
// Shared types and constants for the interval first-fit layering block.
// No dependencies.
`default_nettype none
package iffl_pkg;

  localparam int unsigned LAYER_W    = 6;
  localparam int unsigned NUM_LAYERS = 64;
  localparam int unsigned CFG_W      = 8;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned COORD_W    = 15;
  localparam int unsigned PITCH_W    = 9;

  localparam logic [CFG_IDX_W-1:0] REG_BOX_HEIGHT = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_GAP    = 8'd1;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SCAN = 5'b00010,
    S_PICK = 5'b00100,
    S_MULT = 5'b01000,
    S_DONE = 5'b10000
  } state_e;

  typedef logic [NUM_LAYERS-1:0] layer_mask_t;

endpackage
`default_nettype wire

>>> sv/iffl_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none
module iffl_ram #(
  parameter int unsigned WIDTH = 26,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

>>> sv/iffl_pick.sv
// Lowest-free-layer encoder: finds the lowest clear bit of the blocked mask,
// saturating at the top layer. Depends on iffl_pkg.
`default_nettype none
module iffl_pick
  import iffl_pkg::*;
(
  input  wire layer_mask_t          blocked_i,
  output      logic [LAYER_W-1:0]   layer_o
);

  layer_mask_t low_bits;
  layer_mask_t sum;
  layer_mask_t first_zero;

  // top bit forced clear so a fully blocked mask lands on the top layer
  assign low_bits   = {1'b0, blocked_i[NUM_LAYERS-2:0]};
  assign sum        = low_bits + layer_mask_t'(1);
  assign first_zero = ~low_bits & sum;

  always_comb begin
    layer_o = '0;
    for (int i = 0; i < NUM_LAYERS; i++) begin
      if (first_zero[i]) begin
        layer_o = layer_o | LAYER_W'(i);
      end
    end
  end

endmodule
`default_nettype wire

>>> sv/interval_first_fit_layering_core.sv
// Interval first-fit layering core. An item is taken when start is high and busy is low;
// its result appears for one cycle with done_o high after the scan of the interval store
// (S_SCAN), the layer pick (S_PICK) and the multiply (S_MULT), and busy drops when that
// cycle ends, so a new item is taken only once the last one is through. The scan reads
// one entry per cycle through the single read port of the store's RAM. The receiver
// cannot stall.
// Depends on iffl_pkg, iffl_ram and iffl_pick.
`default_nettype none
module interval_first_fit_layering_core
  import iffl_pkg::*;
#(
  parameter int unsigned MAX_INTERVALS = 64,
  parameter int unsigned TIME_BITS     = 20
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_valid_i,
  output      logic                  cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_W-1:0]      cfg_data_i,
  input  wire logic                  start,
  output      logic                  busy,
  input  wire logic [TIME_BITS-1:0]  start_time_i,
  input  wire logic [TIME_BITS-1:0]  finish_time_i,
  input  wire logic                  first_item_i,
  output      logic                  done_o,
  output      logic [LAYER_W-1:0]    layer_o,
  output      logic [COORD_W-1:0]    top_y_o,
  output      logic [COORD_W-1:0]    bottom_y_o,
  output      logic [LAYER_W-1:0]    max_layer_o,
  output      logic                  full_flag_o
);

  localparam int unsigned ADDR_W = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
  localparam int unsigned CNT_W  = $clog2(MAX_INTERVALS + 1);
  localparam int unsigned ENT_W  = TIME_BITS + LAYER_W;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_INTERVALS);

  state_e              state_q, state_d;
  logic [CFG_W-1:0]    height_q, gap_q;
  logic [TIME_BITS-1:0] start_q, finish_q;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [CNT_W-1:0]    idx_q, idx_d;
  logic                rd_vld_q, rd_vld_d;
  layer_mask_t         blocked_q, blocked_d;
  logic [LAYER_W-1:0]  highest_q, highest_d;
  logic [LAYER_W-1:0]  layer_q;
  logic                full_q;
  logic [COORD_W-1:0]  top_q;

  logic                accept;
  logic                issue;
  logic                ram_we;
  logic [ENT_W-1:0]    ram_rdata;
  logic [TIME_BITS-1:0] rd_finish;
  logic [LAYER_W-1:0]  rd_layer;
  logic [LAYER_W-1:0]  pick_layer;
  logic [PITCH_W-1:0]  pitch;
  logic [COORD_W-1:0]  product;

  assign cfg_ready_o = 1'b1;
  assign accept      = start && !busy;
  assign busy        = (state_q != S_IDLE);
  assign issue       = (state_q == S_SCAN) && (idx_q < count_q);
  assign ram_we      = (state_q == S_MULT) && !full_q;
  assign rd_finish   = ram_rdata[ENT_W-1:LAYER_W];
  assign rd_layer    = ram_rdata[LAYER_W-1:0];
  assign pitch       = PITCH_W'(height_q) + PITCH_W'(gap_q);
  assign product     = COORD_W'(layer_q) * COORD_W'(pitch);

  iffl_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_INTERVALS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[ADDR_W-1:0]),
    .wdata_i ({finish_q, layer_q}),
    .raddr_i (idx_q[ADDR_W-1:0]),
    .rdata_o (ram_rdata)
  );

  iffl_pick u_pick (
    .blocked_i (blocked_q),
    .layer_o   (pick_layer)
  );

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    idx_d     = idx_q;
    rd_vld_d  = 1'b0;
    blocked_d = blocked_q;
    highest_d = highest_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          idx_d     = '0;
          blocked_d = '0;
          if (first_item_i) begin
            count_d   = '0;
            highest_d = '0;
          end
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        rd_vld_d = issue;
        if (issue) begin
          idx_d = idx_q + CNT_W'(1);
        end
        if (rd_vld_q && (start_q < rd_finish)) begin
          blocked_d = blocked_q | (layer_mask_t'(1) << rd_layer);
        end
        if (!issue && !rd_vld_q) begin
          state_d = S_PICK;
        end
      end
      S_PICK: begin
        state_d = S_MULT;
      end
      S_MULT: begin
        if (!full_q) begin
          count_d = count_q + CNT_W'(1);
          if (layer_q > highest_q) begin
            highest_d = layer_q;
          end
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      idx_q     <= '0;
      rd_vld_q  <= 1'b0;
      highest_q <= '0;
      height_q  <= CFG_W'(20);
      gap_q     <= CFG_W'(3);
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      idx_q     <= idx_d;
      rd_vld_q  <= rd_vld_d;
      highest_q <= highest_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          REG_BOX_HEIGHT: height_q <= cfg_data_i;
          REG_BOX_GAP:    gap_q    <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    blocked_q <= blocked_d;
    if (accept) begin
      start_q  <= start_time_i;
      finish_q <= finish_time_i;
    end
    if (state_q == S_PICK) begin
      layer_q <= pick_layer;
      full_q  <= (count_q == CNT_MAX);
    end
    if (state_q == S_MULT) begin
      top_q <= product;
    end
  end

  assign done_o      = (state_q == S_DONE);
  assign layer_o     = layer_q;
  assign top_y_o     = top_q;
  assign bottom_y_o  = top_q + COORD_W'(height_q);
  assign max_layer_o = highest_q;
  assign full_flag_o = full_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_MAX)
    else $error("stored count exceeds store depth");

  a_done_after_mult: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MULT) |=> done_o)
    else $error("result strobe missing after multiply");

  a_max_covers_layer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !full_flag_o) |-> (max_layer_o >= layer_o))
    else $error("running max below stored layer");

  a_no_write_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (count_q < CNT_MAX))
    else $error("store write while full");

  a_scan_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (idx_q <= count_q))
    else $error("scan index past stored count");

endmodule
`default_nettype wire

>>> tb/interval_first_fit_layering_core_tb.sv
// Self-checking testbench for interval_first_fit_layering_core: a scoreboard class predicts
// layer, box coordinates, running max layer and store-full flag for every item.
// Depends on iffl_pkg and the RTL of the core.
module interval_first_fit_layering_core_tb;
  import iffl_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_INTERVALS = 64;
  localparam int unsigned TIME_BITS     = 20;
  localparam int unsigned CYCLE_LIMIT   = 1000000;
  localparam int unsigned PHASE_ITEMS   = 180;

  typedef logic [TIME_BITS-1:0] time_t;

  typedef struct packed {
    logic [LAYER_W-1:0] layer;
    logic [COORD_W-1:0] top_y;
    logic [COORD_W-1:0] bottom_y;
    logic [LAYER_W-1:0] max_layer;
    logic               full;
  } placement_t;

  class layering_board;
    time_t              finish_mem[MAX_INTERVALS];
    logic [LAYER_W-1:0] layer_mem[MAX_INTERVALS];
    int unsigned        count;
    logic [LAYER_W-1:0] highest;
    logic [CFG_W-1:0]   box_height;
    logic [CFG_W-1:0]   box_gap;
    placement_t         pending[$];
    int unsigned        mismatches;
    int unsigned        checked;
    int unsigned        full_hits;
    int unsigned        top_layer_hits;

    function new();
      count      = 0;
      highest    = '0;
      box_height = 8'd20;
      box_gap    = 8'd3;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        REG_BOX_HEIGHT: box_height = val;
        REG_BOX_GAP:    box_gap    = val;
        default: ;
      endcase
    endfunction

    // Predict the placement of one accepted item and advance the stored list.
    function void note_item(time_t t_start, time_t t_finish, logic first);
      layer_mask_t        blocked;
      logic [LAYER_W-1:0] lyr;
      int unsigned        pitch;
      placement_t         want;
      blocked = '0;
      if (first) begin
        count   = 0;
        highest = '0;
      end
      for (int j = 0; j < count; j++) begin
        if (t_start < finish_mem[j]) blocked[layer_mem[j]] = 1'b1;
      end
      lyr = LAYER_W'(NUM_LAYERS - 1);
      for (int k = NUM_LAYERS - 2; k >= 0; k--) begin
        if (!blocked[k]) lyr = LAYER_W'(k);
      end
      pitch         = 32'(box_height) + 32'(box_gap);
      want.layer    = lyr;
      want.top_y    = COORD_W'(lyr * pitch);
      want.bottom_y = COORD_W'(lyr * pitch + box_height);
      want.full     = (count >= MAX_INTERVALS);
      if (!want.full) begin
        finish_mem[count] = t_finish;
        layer_mem[count]  = lyr;
        count++;
        if (lyr > highest) highest = lyr;
      end
      want.max_layer = highest;
      if (want.full) full_hits++;
      if (lyr == LAYER_W'(NUM_LAYERS - 1)) top_layer_hits++;
      pending = {pending, want};
    endfunction

    function void check_result(placement_t got);
      placement_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result, layer %0d top %0d", $time, got.layer, got.top_y);
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got.layer !== want.layer || got.top_y !== want.top_y ||
          got.bottom_y !== want.bottom_y || got.max_layer !== want.max_layer ||
          got.full !== want.full) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: layer/top/bot/max/full exp %0d/%0d/%0d/%0d/%0b got %0d/%0d/%0d/%0d/%0b",
                   $time, want.layer, want.top_y, want.bottom_y, want.max_layer, want.full,
                   got.layer, got.top_y, got.bottom_y, got.max_layer, got.full);
      end
    endfunction
  endclass

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_valid_i   = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i   = '0;
  logic [CFG_W-1:0]     cfg_data_i    = '0;
  logic                 start         = 1'b0;
  logic                 busy;
  time_t                start_time_i  = '0;
  time_t                finish_time_i = '0;
  logic                 first_item_i  = 1'b0;
  logic                 done_o;
  logic [LAYER_W-1:0]   layer_o;
  logic [COORD_W-1:0]   top_y_o;
  logic [COORD_W-1:0]   bottom_y_o;
  logic [LAYER_W-1:0]   max_layer_o;
  logic                 full_flag_o;

  layering_board board = new();
  int unsigned   cycles;
  int unsigned   burst_left;
  int unsigned   item_count;
  int unsigned   list_count;
  int unsigned   setting_count;

  interval_first_fit_layering_core #(
    .MAX_INTERVALS(MAX_INTERVALS),
    .TIME_BITS    (TIME_BITS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .start        (start),
    .busy         (busy),
    .start_time_i (start_time_i),
    .finish_time_i(finish_time_i),
    .first_item_i (first_item_i),
    .done_o       (done_o),
    .layer_o      (layer_o),
    .top_y_o      (top_y_o),
    .bottom_y_o   (bottom_y_o),
    .max_layer_o  (max_layer_o),
    .full_flag_o  (full_flag_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("interval_first_fit_layering_core regression: fail");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    placement_t got;
    if (rst_ni && done_o) begin
      got = '{layer: layer_o, top_y: top_y_o, bottom_y: bottom_y_o,
              max_layer: max_layer_o, full: full_flag_o};
      board.check_result(got);
    end
  end

  // Present one item, wait for it to be taken, then keep going or pause per burst pacing.
  task automatic send_item(time_t t_start, time_t t_finish, logic first);
    start_time_i  <= t_start;
    finish_time_i <= t_finish;
    first_item_i  <= first;
    start         <= 1'b1;
    do @(posedge clk_i); while (busy);
    board.note_item(t_start, t_finish, first);
    item_count++;
    if (burst_left == 0) begin
      start      <= 1'b0;
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10);
      repeat ($urandom_range(1, 80)) @(posedge clk_i);
    end else begin
      burst_left--;
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
    burst_left = 0;
  endtask

  task automatic set_config(logic [CFG_W-1:0] height, logic [CFG_W-1:0] gap);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= REG_BOX_HEIGHT;
    cfg_data_i  <= height;
    do @(posedge clk_i); while (!cfg_ready_o);
    board.set_reg(REG_BOX_HEIGHT, height);
    cfg_index_i <= REG_BOX_GAP;
    cfg_data_i  <= gap;
    do @(posedge clk_i); while (!cfg_ready_o);
    board.set_reg(REG_BOX_GAP, gap);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
    setting_count++;
  endtask

  // Every interval overlaps every other: fills all layers, then the store.
  task automatic run_stack();
    for (int i = 0; i < MAX_INTERVALS + 2; i++)
      send_item(time_t'($urandom_range(0, 20'h3FFFF)),
                time_t'($urandom_range(20'h80000, 20'hFFFFF)), i == 0);
    list_count++;
  endtask

  task automatic run_list();
    int unsigned kind;
    int unsigned len;
    time_t       t;
    time_t       s;
    time_t       f;
    time_t       last_f;
    kind   = $urandom_range(0, 9);
    len    = (kind == 7) ? $urandom_range(55, 70) : $urandom_range(1, 24);
    t      = time_t'($urandom);
    last_f = t;
    for (int i = 0; i < len; i++) begin
      if (kind >= 8) begin
        send_item(time_t'($urandom), time_t'($urandom), logic'($urandom_range(0, 1)));
      end else begin
        if (i > 0 && $urandom_range(0, 3) == 0) begin
          s = last_f;
        end else begin
          t = t + time_t'($urandom_range(0, 60));
          s = t;
        end
        if ($urandom_range(0, 15) == 0) f = s - time_t'($urandom_range(1, 50));
        else f = s + time_t'($urandom_range(0, 400));
        last_f = f;
        send_item(s, f, i == 0);
      end
    end
    list_count++;
  endtask

  initial begin
    int unsigned phase_start;
    logic [CFG_W-1:0] heights[4];
    logic [CFG_W-1:0] gaps[4];
    heights = '{8'd0, 8'd255, 8'd255, 8'd0};
    gaps    = '{8'd0, 8'd255, 8'd0, 8'd255};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: extreme times, equal start/finish, reversed intervals, mid-list clear.
    send_item(20'h00000, 20'h00000, 1'b0);
    send_item(20'h00000, 20'hFFFFF, 1'b0);
    send_item(20'hFFFFF, 20'hFFFFF, 1'b0);
    send_item(20'd10,    20'd5,     1'b0);
    send_item(20'd4,     20'd20,    1'b0);
    send_item(20'd5,     20'd6,     1'b0);
    send_item(20'hFFFFE, 20'h00001, 1'b0);
    send_item(20'd100,   20'd200,   1'b1);
    send_item(20'd200,   20'd300,   1'b0);
    send_item(20'd199,   20'd250,   1'b0);
    send_item(20'd250,   20'd260,   1'b0);
    send_item(20'h00000, 20'hAAAAA, 1'b0);
    send_item(20'h55555, 20'h55555, 1'b0);
    send_item(20'hFFFFF, 20'h00000, 1'b1);
    list_count += 2;
    drain();

    for (int p = 0; p < 8; p++) begin
      if (p < 4) set_config(heights[p], gaps[p]);
      else set_config(CFG_W'($urandom), CFG_W'($urandom));
      run_stack();
      phase_start = item_count;
      while (item_count - phase_start < PHASE_ITEMS) run_list();
      drain();
    end

    drain();
    $display("%0d items in %0d lists over %0d register settings; %0d results checked",
             item_count, list_count, setting_count + 1, board.checked);
    $display("store-full results: %0d, top-layer results: %0d",
             board.full_hits, board.top_layer_hits);
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("interval_first_fit_layering_core regression: pass");
    end else begin
      $display("interval_first_fit_layering_core regression: fail");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/iffl_pkg.sv
sv/iffl_ram.sv
sv/iffl_pick.sv
sv/interval_first_fit_layering_core.sv
tb/interval_first_fit_layering_core_tb.sv
